### hw/rtl/erqt_pkg.sv
`default_nettype none

package erqt_pkg;

  localparam int unsigned ENTITIES = 64;
  localparam int unsigned IDX_W    = (ENTITIES > 1) ? $clog2(ENTITIES) : 1;
  localparam int unsigned COORD_W  = 32;
  localparam int unsigned BND_W    = COORD_W + 2;
  localparam int unsigned RAD_W    = 31;
  localparam int unsigned SQ_W     = 2 * RAD_W;
  localparam int unsigned TILE_W   = 16;
  localparam int unsigned CFG_W    = 16;

  localparam logic [CFG_W-1:0] TILE_SIZE_RST = 16'd8192;

  typedef enum logic [2:0] {
    FUNC_CLEAR  = 3'd0,
    FUNC_LOAD   = 3'd1,
    FUNC_RECT   = 3'd2,
    FUNC_RADIUS = 3'd3,
    FUNC_TILE   = 3'd4
  } func_e;

endpackage

`default_nettype wire

### hw/rtl/erqt_ram.sv
`default_nettype none

module erqt_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                                      clk_i,
  input  wire logic                                      we_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                          wdata_i,
  input  wire logic                                      re_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic      [WIDTH-1:0]                          rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

### hw/rtl/entity_range_query_table.sv
`default_nettype none

// Table of ENTITIES entity positions (signed Q24.8) with a present flag each, answering
// rectangle, radius and tile queries. Clear and load give no word. A query runs a setup
// step for the bounds and r*r, then one table read per cycle, while the output is not
// stalled, through the single read port of the position RAM, a three-stage compare
// pipeline (box test, squares, sum compare) and the closing word. Matches come out in
// ascending id order, the last one flagged; a query with no match gives one word with
// found low and last high. Output stall freezes the scan. No new word is taken until the
// closing word is registered.
module entity_range_query_table
  import erqt_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [CFG_W-1:0]    cfg_data_i,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire logic [2:0]          func_i,
  input  wire logic [5:0]          entity_id_i,
  input  wire logic                entity_present_i,
  input  wire logic [COORD_W-1:0]  coord_x_i,
  input  wire logic [COORD_W-1:0]  coord_y_i,
  input  wire logic [COORD_W-1:0]  extent_w_i,
  input  wire logic [COORD_W-1:0]  extent_h_i,
  input  wire logic [RAD_W-1:0]    radius_i,
  input  wire logic [TILE_W-1:0]   tile_x_i,
  input  wire logic [TILE_W-1:0]   tile_y_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output logic [5:0]               match_id_o,
  output logic                     found_o,
  output logic                     last_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_SCAN,
    ST_DRAIN,
    ST_FLUSH
  } state_e;

  state_e state_q;

  logic [CFG_W-1:0]    tile_size_q;
  logic [ENTITIES-1:0] pres_q;
  logic [IDX_W-1:0]    idx_q;

  // query fields
  func_e               func_q;
  logic [COORD_W-1:0]  cx_q, cy_q, w_q, h_q;
  logic [RAD_W-1:0]    r_q;
  logic [TILE_W-1:0]   tx_q, ty_q;

  logic signed [BND_W-1:0] x0_q, x1_q, y0_q, y1_q;
  logic signed [BND_W-1:0] x0_d, x1_d, y0_d, y1_d;
  logic [SQ_W-1:0]         rr_q;

  // pipeline
  logic                s1_v_q, s1_pres_q, s1_last_q;
  logic [IDX_W-1:0]    s1_id_q;
  logic [2*COORD_W-1:0] rd_data;
  logic                s2_v_q, s2_hit_q, s2_last_q;
  logic [IDX_W-1:0]    s2_id_q;
  logic [RAD_W-1:0]    dx_q, dy_q;
  logic                s3_v_q, s3_hit_q, s3_last_q;
  logic [IDX_W-1:0]    s3_id_q;
  logic [SQ_W-1:0]     sqx_q, sqy_q;

  logic                pend_v_q;
  logic [IDX_W-1:0]    pend_id_q;

  logic accept, adv, issue, load_we, match, emit_pend, emit_flush;
  logic signed [BND_W-1:0]   px, py;
  logic signed [COORD_W:0]   dxs, dys, dxa, dya;
  logic                      in_box;
  logic [SQ_W:0]             sq_sum;

  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign adv        = !out_valid_o || !out_stall_i;
  assign issue      = (state_q == ST_SCAN) && adv;
  assign load_we    = accept && (func_e'(func_i) == FUNC_LOAD)
                      && ({1'b0, entity_id_i} < 7'(ENTITIES));

  erqt_ram #(
    .WIDTH (2 * COORD_W),
    .DEPTH (ENTITIES)
  ) u_pos_ram (
    .clk_i   (clk_i),
    .we_i    (load_we),
    .waddr_i (entity_id_i[IDX_W-1:0]),
    .wdata_i ({coord_x_i, coord_y_i}),
    .re_i    (adv),
    .raddr_i (idx_q),
    .rdata_o (rd_data)
  );

  // query bounds
  always_comb begin
    case (func_q)
      FUNC_RECT: begin
        x0_d = BND_W'($signed(cx_q));
        y0_d = BND_W'($signed(cy_q));
        x1_d = BND_W'($signed(cx_q)) + BND_W'($signed(w_q));
        y1_d = BND_W'($signed(cy_q)) + BND_W'($signed(h_q));
      end
      FUNC_RADIUS: begin
        x0_d = BND_W'($signed(cx_q)) - $signed(BND_W'(r_q));
        y0_d = BND_W'($signed(cy_q)) - $signed(BND_W'(r_q));
        x1_d = BND_W'($signed(cx_q)) + $signed(BND_W'(r_q));
        y1_d = BND_W'($signed(cy_q)) + $signed(BND_W'(r_q));
      end
      default: begin
        // tile: corner tx*ts, far edge (tx+1)*ts
        x0_d = BND_W'($signed({tx_q[TILE_W-1], tx_q}))
               * BND_W'($signed({1'b0, tile_size_q}));
        y0_d = BND_W'($signed({ty_q[TILE_W-1], ty_q}))
               * BND_W'($signed({1'b0, tile_size_q}));
        x1_d = BND_W'($signed({tx_q[TILE_W-1], tx_q}) + 17'sd1)
               * BND_W'($signed({1'b0, tile_size_q}));
        y1_d = BND_W'($signed({ty_q[TILE_W-1], ty_q}) + 17'sd1)
               * BND_W'($signed({1'b0, tile_size_q}));
      end
    endcase
  end

  // box test and distances
  always_comb begin
    px     = BND_W'($signed(rd_data[2*COORD_W-1:COORD_W]));
    py     = BND_W'($signed(rd_data[COORD_W-1:0]));
    in_box = (px >= x0_q) && (px <= x1_q) && (py >= y0_q) && (py <= y1_q);
    dxs    = (COORD_W+1)'($signed(rd_data[2*COORD_W-1:COORD_W])) - (COORD_W+1)'($signed(cx_q));
    dys    = (COORD_W+1)'($signed(rd_data[COORD_W-1:0])) - (COORD_W+1)'($signed(cy_q));
    dxa    = dxs[COORD_W] ? -dxs : dxs;
    dya    = dys[COORD_W] ? -dys : dys;
  end

  assign sq_sum     = {1'b0, sqx_q} + {1'b0, sqy_q};
  assign match      = s3_v_q && s3_hit_q
                      && ((func_q != FUNC_RADIUS) || (sq_sum <= {1'b0, rr_q}));
  assign emit_pend  = adv && match && pend_v_q;
  assign emit_flush = adv && (state_q == ST_FLUSH);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      tile_size_q <= TILE_SIZE_RST;
      pres_q      <= '0;
      idx_q       <= '0;
      s1_v_q      <= 1'b0;
      s2_v_q      <= 1'b0;
      s3_v_q      <= 1'b0;
      pend_v_q    <= 1'b0;
      out_valid_o <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        tile_size_q <= cfg_data_i;
      end
      if (adv) begin
        s1_v_q <= issue;
        s2_v_q <= s1_v_q;
        s3_v_q <= s2_v_q;
      end
      if (emit_pend || emit_flush) begin
        out_valid_o <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_o <= 1'b0;
      end
      if (adv && match) begin
        pend_v_q <= 1'b1;
      end
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            pend_v_q <= 1'b0;
            case (func_e'(func_i))
              FUNC_CLEAR: pres_q <= '0;
              FUNC_LOAD: begin
                if (load_we) begin
                  pres_q[entity_id_i[IDX_W-1:0]] <= entity_present_i;
                end
              end
              FUNC_RECT, FUNC_RADIUS, FUNC_TILE: state_q <= ST_SETUP;
              default: ;
            endcase
          end
        end
        ST_SETUP: begin
          idx_q   <= '0;
          state_q <= ST_SCAN;
        end
        ST_SCAN: begin
          if (issue) begin
            idx_q <= idx_q + 1'b1;
            if (idx_q == IDX_W'(ENTITIES - 1)) begin
              state_q <= ST_DRAIN;
            end
          end
        end
        ST_DRAIN: begin
          if (adv && s3_v_q && s3_last_q) begin
            state_q <= ST_FLUSH;
          end
        end
        ST_FLUSH: begin
          if (adv) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      func_q <= func_e'(func_i);
      cx_q   <= coord_x_i;
      cy_q   <= coord_y_i;
      w_q    <= extent_w_i;
      h_q    <= extent_h_i;
      r_q    <= radius_i;
      tx_q   <= tile_x_i;
      ty_q   <= tile_y_i;
    end
    if (state_q == ST_SETUP) begin
      x0_q <= x0_d;
      x1_q <= x1_d;
      y0_q <= y0_d;
      y1_q <= y1_d;
      rr_q <= SQ_W'(r_q) * SQ_W'(r_q);
    end
    if (adv) begin
      s1_id_q   <= idx_q;
      s1_pres_q <= pres_q[idx_q];
      s1_last_q <= (idx_q == IDX_W'(ENTITIES - 1));
      s2_id_q   <= s1_id_q;
      s2_last_q <= s1_last_q;
      s2_hit_q  <= s1_pres_q && in_box;
      dx_q      <= dxa[RAD_W-1:0];
      dy_q      <= dya[RAD_W-1:0];
      s3_id_q   <= s2_id_q;
      s3_last_q <= s2_last_q;
      s3_hit_q  <= s2_hit_q;
      sqx_q     <= SQ_W'(dx_q) * SQ_W'(dx_q);
      sqy_q     <= SQ_W'(dy_q) * SQ_W'(dy_q);
      if (match) begin
        pend_id_q <= s3_id_q;
      end
    end
    // a match goes out only once the next one, or the scan end, is known
    if (emit_pend) begin
      match_id_o <= 6'(pend_id_q);
      found_o    <= 1'b1;
      last_o     <= 1'b0;
    end else if (emit_flush) begin
      match_id_o <= pend_v_q ? 6'(pend_id_q) : 6'd0;
      found_o    <= pend_v_q;
      last_o     <= 1'b1;
    end
  end

endmodule

`default_nettype wire
